[design/mig_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_pkg
// Shared constants, types and helpers of the Gauss-Jordan matrix inverter.
// ----------------------------------------------------------------------------
package mig_pkg;

    localparam int MAX_N     = 8;
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int SIZE_W    = 4;
    localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW        = IDX_W + 1;
    localparam int STRIDE    = 2 * MAX_N;
    localparam int DEPTH     = 2 * MAX_N * MAX_N;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW        = DW + FRAC_BITS;
    localparam int DCNT_W    = $clog2(QW);

    typedef enum logic [2:0] {
        WS_INPUT = 3'd0,
        WS_ONE   = 3'd1,
        WS_ZERO  = 3'd2,
        WS_RDATA = 3'd3,
        WS_PROW  = 3'd4,
        WS_DIV   = 3'd5,
        WS_ELIM  = 3'd6
    } t_wsel;

    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        t_wsel         wr_sel;
        logic          prow_we;
        logic          prow_from_div;
        logic [CW-1:0] prow_idx;
        logic          pivot_ld;
        logic          factor_ld;
        logic          div_start;
        logic          mul_en;
        logic          out_load;
        logic          out_sing;
        logic          out_last;
        logic          ovf_clr;
    } t_cmd;

    typedef struct packed {
        logic rdata_zero;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(int'(row) * STRIDE + int'(col));
    endfunction

endpackage
`default_nettype wire

[design/mig_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_div
// Radix-2 restoring divider for (a * 2^FRAC_BITS) / p with saturation.
// ----------------------------------------------------------------------------
module mig_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire signed [mig_pkg::DW-1:0] i_num,
    input  wire signed [mig_pkg::DW-1:0] i_den,
    output logic                        o_done,
    output logic signed [mig_pkg::DW-1:0] o_quot,
    output logic                        o_ovf
);
    localparam int QW = mig_pkg::QW;
    localparam int DW = mig_pkg::DW;

    logic                      r_busy;
    logic                      r_done;
    logic [mig_pkg::DCNT_W-1:0] r_cnt;
    logic [QW-1:0]             r_num;
    logic [QW-1:0]             r_q;
    logic [DW-1:0]             r_den;
    logic [DW-1:0]             r_rem;
    logic                      r_neg;

    logic [DW:0]   rem_sh;
    logic          fits;
    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;

    assign num_mag = i_num[DW-1] ? DW'(~i_num + 1'b1) : DW'(i_num);
    assign den_mag = i_den[DW-1] ? DW'(~i_den + 1'b1) : DW'(i_den);
    assign rem_sh  = {r_rem, r_num[QW-1]};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == mig_pkg::DCNT_W'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {num_mag, {mig_pkg::FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_rem <= fits ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
            r_q   <= {r_q[QW-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        o_ovf  = 1'b0;
        o_quot = DW'(r_q);
        if (r_neg) begin
            if (r_q > QW'({1'b1, {(DW-1){1'b0}}})) begin
                o_ovf  = 1'b1;
                o_quot = {1'b1, {(DW-1){1'b0}}};
            end else begin
                o_quot = DW'(~r_q + 1'b1);
            end
        end else if (r_q > QW'({1'b0, {(DW-1){1'b1}}})) begin
            o_ovf  = 1'b1;
            o_quot = {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

[design/mig_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_datapath
// Augmented-matrix memory, pivot row buffer, divider, multiply-subtract and
// output register of the matrix inverter.
// ----------------------------------------------------------------------------
module mig_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mig_pkg::t_cmd                i_cmd,
    output mig_pkg::t_sts                o_sts,
    input  wire signed [mig_pkg::DW-1:0] i_elem_value,
    input  wire                          i_stall,
    output logic                         o_valid,
    output logic signed [mig_pkg::DW-1:0] o_inv_value,
    output logic                         o_singular,
    output logic                         o_overflow,
    output logic                         o_last_out
);
    localparam int DW = mig_pkg::DW;

    logic signed [DW-1:0] r_mem [mig_pkg::DEPTH];
    logic signed [DW-1:0] r_prow [mig_pkg::STRIDE];
    logic signed [DW-1:0] r_rdata;
    logic signed [DW-1:0] r_pivot;
    logic signed [DW-1:0] r_factor;
    logic signed [DW-1:0] r_x;
    logic signed [2*DW-1:0] r_prod;
    logic                 r_ovf;
    logic                 r_ovalid;
    logic signed [DW-1:0] r_oval;
    logic                 r_osing;
    logic                 r_oovf;
    logic                 r_olast;

    logic                 div_done;
    logic signed [DW-1:0] div_q;
    logic                 div_ovf;
    logic signed [2*DW-1:0] rnd;
    logic signed [2*DW:0] diff;
    logic signed [DW-1:0] elim_val;
    logic                 elim_ovf;
    logic signed [DW-1:0] wdata;

    mig_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_rdata),
        .i_den   (r_pivot),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_ovf   (div_ovf)
    );

    always_comb begin
        rnd      = (r_prod + (2*DW)'(64'sd1 <<< (mig_pkg::FRAC_BITS - 1)))
                   >>> mig_pkg::FRAC_BITS;
        diff     = (2*DW+1)'(r_x) - (2*DW+1)'(rnd);
        elim_ovf = 1'b1;
        if (diff > (2*DW+1)'(64'sd2147483647)) begin
            elim_val = {1'b0, {(DW-1){1'b1}}};
        end else if (diff < -(2*DW+1)'(64'sd2147483648)) begin
            elim_val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            elim_val = DW'(diff);
            elim_ovf = 1'b0;
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            mig_pkg::WS_INPUT: wdata = i_elem_value;
            mig_pkg::WS_ONE:   wdata = DW'(1) <<< mig_pkg::FRAC_BITS;
            mig_pkg::WS_RDATA: wdata = r_rdata;
            mig_pkg::WS_PROW:  wdata = r_prow[i_cmd.prow_idx];
            mig_pkg::WS_DIV:   wdata = div_q;
            mig_pkg::WS_ELIM:  wdata = elim_val;
            default:           wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prow_we) begin
            r_prow[i_cmd.prow_idx] <= i_cmd.prow_from_div ? div_q : r_rdata;
        end
        if (i_cmd.pivot_ld) begin
            r_pivot <= r_rdata;
        end
        if (i_cmd.factor_ld) begin
            r_factor <= r_rdata;
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_factor * r_prow[i_cmd.prow_idx];
            r_x    <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_oval  <= i_cmd.out_sing ? '0 : r_rdata;
            r_osing <= i_cmd.out_sing;
            r_oovf  <= r_ovf;
            r_olast <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.ovf_clr) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.wr_en && ((i_cmd.wr_sel == mig_pkg::WS_DIV && div_ovf) ||
                                         (i_cmd.wr_sel == mig_pkg::WS_ELIM && elim_ovf))) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.rdata_zero = (r_rdata == '0);
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_ovalid || !i_stall;

    assign o_valid     = r_ovalid;
    assign o_inv_value = r_oval;
    assign o_singular  = r_osing;
    assign o_overflow  = r_oovf;
    assign o_last_out  = r_olast;

endmodule
`default_nettype wire

[design/mig_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_ctrl
// Sequencer for loading, pivoting, normalization, elimination and readout.
// ----------------------------------------------------------------------------
module mig_ctrl (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [mig_pkg::SIZE_W-1:0]      i_cfg_data,
    output mig_pkg::t_cmd                  o_cmd,
    input  mig_pkg::t_sts                  i_sts
);
    localparam int IDX_W = mig_pkg::IDX_W;
    localparam int CW    = mig_pkg::CW;

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_INIT      = 23'h000002,
        S_PIV_RD    = 23'h000004,
        S_PIV_CHK   = 23'h000008,
        S_SRCH_RD   = 23'h000010,
        S_SRCH_CHK  = 23'h000020,
        S_SWA_RD    = 23'h000040,
        S_SWA_WR    = 23'h000080,
        S_SWB_RD    = 23'h000100,
        S_SWB_WR    = 23'h000200,
        S_SWB_W2    = 23'h000400,
        S_NORM_RD   = 23'h000800,
        S_NORM_GO   = 23'h001000,
        S_NORM_WAIT = 23'h002000,
        S_ELIM_K    = 23'h004000,
        S_ELIM_F    = 23'h008000,
        S_ELIM_RD   = 23'h010000,
        S_ELIM_MUL  = 23'h020000,
        S_ELIM_WR   = 23'h040000,
        S_NEXT      = 23'h080000,
        S_OUT_RD    = 23'h100000,
        S_OUT_LD    = 23'h200000,
        S_SING      = 23'h400000
    } t_state;

    t_state                      r_state, n_state;
    logic [mig_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [IDX_W-1:0]            r_r, n_r, r_c, n_c, r_i, n_i, r_k, n_k;
    logic [CW-1:0]               r_j, n_j;

    logic [IDX_W-1:0] nm1;
    logic [CW-1:0]    jlast;
    logic [CW-1:0]    ncol;
    logic             rc_last_c;
    logic             rc_last;
    logic             j_last;

    always_comb begin
        if (r_size == '0) begin
            nm1 = '0;
        end else if (r_size > mig_pkg::SIZE_W'(mig_pkg::MAX_N)) begin
            nm1 = IDX_W'(mig_pkg::MAX_N - 1);
        end else begin
            nm1 = IDX_W'(r_size - 1'b1);
        end
    end

    assign jlast     = {nm1, 1'b1};
    assign ncol      = {1'b0, nm1} + CW'(1) + {1'b0, r_c};
    assign rc_last_c = (r_c == nm1);
    assign rc_last   = rc_last_c && (r_r == nm1);
    assign j_last    = (r_j == jlast);

    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_r     = r_r;
        n_c     = r_c;
        n_i     = r_i;
        n_k     = r_k;
        n_j     = r_j;
        o_cmd          = '0;
        o_cmd.wr_sel   = mig_pkg::WS_ZERO;
        o_cmd.prow_idx = r_j;
        o_stall        = 1'b1;
        o_cfg_ready    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_stall     = i_cfg_valid;
                if (i_cfg_valid) begin
                    n_size = i_cfg_data;
                    n_r    = '0;
                    n_c    = '0;
                end else if (i_valid) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = mig_pkg::cell_addr(r_r, {1'b0, r_c});
                    o_cmd.wr_sel  = mig_pkg::WS_INPUT;
                    n_c = rc_last_c ? '0 : r_c + 1'b1;
                    if (rc_last_c) begin
                        n_r = (r_r == nm1) ? '0 : r_r + 1'b1;
                    end
                    if (rc_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mig_pkg::cell_addr(r_r, ncol);
                o_cmd.wr_sel  = (r_r == r_c) ? mig_pkg::WS_ONE : mig_pkg::WS_ZERO;
                n_c = rc_last_c ? '0 : r_c + 1'b1;
                if (rc_last_c) begin
                    n_r = (r_r == nm1) ? '0 : r_r + 1'b1;
                end
                if (rc_last) begin
                    n_i     = '0;
                    n_state = S_PIV_RD;
                end
            end
            S_PIV_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_i, {1'b0, r_i});
                n_state       = S_PIV_CHK;
            end
            S_PIV_CHK: begin
                o_cmd.pivot_ld = 1'b1;
                n_j            = '0;
                if (!i_sts.rdata_zero) begin
                    n_state = S_NORM_RD;
                end else if (r_i == nm1) begin
                    n_state = S_SING;
                end else begin
                    n_k     = r_i + 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_k, {1'b0, r_i});
                n_state       = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (!i_sts.rdata_zero) begin
                    o_cmd.pivot_ld = 1'b1;
                    n_j            = '0;
                    n_state        = S_SWA_RD;
                end else if (r_k == nm1) begin
                    n_state = S_SING;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_SWA_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_i, r_j);
                n_state       = S_SWA_WR;
            end
            S_SWA_WR: begin
                o_cmd.prow_we = 1'b1;
                n_j     = j_last ? '0 : r_j + 1'b1;
                n_state = j_last ? S_SWB_RD : S_SWA_RD;
            end
            S_SWB_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_k, r_j);
                n_state       = S_SWB_WR;
            end
            S_SWB_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mig_pkg::cell_addr(r_i, r_j);
                o_cmd.wr_sel  = mig_pkg::WS_RDATA;
                n_state       = S_SWB_W2;
            end
            S_SWB_W2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mig_pkg::cell_addr(r_k, r_j);
                o_cmd.wr_sel  = mig_pkg::WS_PROW;
                n_j     = j_last ? '0 : r_j + 1'b1;
                n_state = j_last ? S_NORM_RD : S_SWB_RD;
            end
            S_NORM_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_i, r_j);
                n_state       = S_NORM_GO;
            end
            S_NORM_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_en         = 1'b1;
                    o_cmd.wr_addr       = mig_pkg::cell_addr(r_i, r_j);
                    o_cmd.wr_sel        = mig_pkg::WS_DIV;
                    o_cmd.prow_we       = 1'b1;
                    o_cmd.prow_from_div = 1'b1;
                    n_j = j_last ? '0 : r_j + 1'b1;
                    n_k = '0;
                    n_state = j_last ? S_ELIM_K : S_NORM_RD;
                end
            end
            S_ELIM_K: begin
                if (r_k == r_i) begin
                    n_k     = r_k + 1'b1;
                    n_state = (r_k == nm1) ? S_NEXT : S_ELIM_K;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = mig_pkg::cell_addr(r_k, {1'b0, r_i});
                    n_state       = S_ELIM_F;
                end
            end
            S_ELIM_F: begin
                o_cmd.factor_ld = 1'b1;
                n_j             = '0;
                n_state         = S_ELIM_RD;
            end
            S_ELIM_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_k, r_j);
                n_state       = S_ELIM_MUL;
            end
            S_ELIM_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_ELIM_WR;
            end
            S_ELIM_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mig_pkg::cell_addr(r_k, r_j);
                o_cmd.wr_sel  = mig_pkg::WS_ELIM;
                n_j = j_last ? '0 : r_j + 1'b1;
                if (!j_last) begin
                    n_state = S_ELIM_RD;
                end else if (r_k == nm1) begin
                    n_state = S_NEXT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_ELIM_K;
                end
            end
            S_NEXT: begin
                n_r = '0;
                n_c = '0;
                n_i = r_i + 1'b1;
                n_state = (r_i == nm1) ? S_OUT_RD : S_PIV_RD;
            end
            S_OUT_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = mig_pkg::cell_addr(r_r, ncol);
                n_state       = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = rc_last;
                    o_cmd.ovf_clr  = rc_last;
                    n_c = rc_last_c ? '0 : r_c + 1'b1;
                    if (rc_last_c) begin
                        n_r = (r_r == nm1) ? '0 : r_r + 1'b1;
                    end
                    n_state = rc_last ? S_IDLE : S_OUT_RD;
                end
            end
            S_SING: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sing = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.ovf_clr  = 1'b1;
                    n_r     = '0;
                    n_c     = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= mig_pkg::SIZE_W'(mig_pkg::MAX_N);
            r_r     <= '0;
            r_c     <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_r     <= n_r;
            r_c     <= n_c;
            r_i     <= n_i;
            r_k     <= n_k;
            r_j     <= n_j;
        end
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("Result loaded while the output register is occupied.");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> (r_state == S_IDLE))
        else $error("Final result did not return the sequencer to idle.");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_NORM_WAIT))
        else $error("Divider finished outside normalization.");

endmodule
`default_nettype wire

[design/matrix_inverse_gauss_jordan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan
// Signed Q16.16 Gauss-Jordan matrix inverter with saturation.
// ----------------------------------------------------------------------------
// The block takes N*N elements one per transfer, row-major, and then inverts
// the matrix in one memory with one shared radix-2 divider. For each pivot it
// swaps in a lower row with a nonzero pivot when needed, normalizes the pivot
// row and then eliminates the pivot column from each of the other N-1 rows.
// Results leave through an output register, which holds each result while
// i_stall is high. New elements and size writes are taken only while the
// block is idle.
module matrix_inverse_gauss_jordan (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire signed [31:0]             i_elem_value,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic signed [31:0]            o_inv_value,
    output logic                          o_singular,
    output logic                          o_overflow,
    output logic                          o_last_out,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [3:0]                     i_cfg_data
);
    mig_pkg::t_cmd cmd;
    mig_pkg::t_sts sts;

    mig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mig_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_elem_value (i_elem_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_inv_value  (o_inv_value),
        .o_singular   (o_singular),
        .o_overflow   (o_overflow),
        .o_last_out   (o_last_out)
    );

endmodule
`default_nettype wire

[tb/tb_matrix_inverse_gauss_jordan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_gauss_jordan
// Loads matrices of several orders into the Gauss-Jordan inverter under random
// input gaps and output stalls, computes the expected Q16.16 inverse with its
// own elimination model, and compares every result field in order.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_gauss_jordan;

    typedef struct {
        logic signed [31:0] value;
        logic               singular;
        logic               overflow;
        logic               last;
    } inv_result_t;

    class inverse_scoreboard;
        int                 size_reg;
        int                 loaded;
        bit                 sat_seen;
        int                 grid [mig_pkg::DEPTH];
        inv_result_t        pending [$];
        int                 errors;

        function void clear();
            size_reg = 8;
            loaded = 0;
            sat_seen = 0;
            errors = 0;
            foreach (grid[i]) grid[i] = 0;
        endfunction

        function void note_size(logic [mig_pkg::SIZE_W-1:0] v);
            size_reg = v;
            loaded = 0;
        endfunction

        function int order();
            if (size_reg < 1) return 1;
            if (size_reg > mig_pkg::MAX_N) return mig_pkg::MAX_N;
            return size_reg;
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647) begin
                sat_seen = 1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648) begin
                sat_seen = 1;
                return 32'sh80000000;
            end
            return int'(v);
        endfunction

        function int at(int r, int c);
            return (r * mig_pkg::STRIDE + c) & (mig_pkg::DEPTH - 1);
        endfunction

        function bit reduce(int n);
            int     piv, pr, tmp;
            longint num, fac, prod;
            for (int i = 0; i < n; i++) begin
                piv = grid[at(i, i)];
                if (piv == 0) begin
                    pr = -1;
                    for (int k = i + 1; k < n; k++) begin
                        if (grid[at(k, i)] != 0 && pr < 0) pr = k;
                    end
                    if (pr < 0) return 0;
                    for (int j = 0; j < 2 * n; j++) begin
                        tmp = grid[at(pr, j)];
                        grid[at(pr, j)] = grid[at(i, j)];
                        grid[at(i, j)] = tmp;
                    end
                    piv = grid[at(i, i)];
                end
                for (int j = 0; j < 2 * n; j++) begin
                    num = longint'(grid[at(i, j)]) <<< mig_pkg::FRAC_BITS;
                    grid[at(i, j)] = clamp32(num / longint'(piv));
                end
                for (int k = 0; k < n; k++) begin
                    if (k != i) begin
                        fac = grid[at(k, i)];
                        for (int j = 0; j < 2 * n; j++) begin
                            prod = fac * longint'(grid[at(i, j)]);
                            prod = (prod + (64'sd1 <<< (mig_pkg::FRAC_BITS - 1)))
                                   >>> mig_pkg::FRAC_BITS;
                            grid[at(k, j)] = clamp32(longint'(grid[at(k, j)]) - prod);
                        end
                    end
                end
            end
            return 1;
        endfunction

        function void note_elem(logic signed [31:0] v);
            int          n;
            inv_result_t res;
            n = order();
            if (loaded >= n * n) loaded = 0;
            grid[at(loaded / n, loaded % n)] = v;
            loaded++;
            if (loaded < n * n) return;
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    grid[at(r, n + c)] = (r == c) ? (1 << mig_pkg::FRAC_BITS) : 0;
                end
            end
            if (!reduce(n)) begin
                res.value = 0;
                res.singular = 1;
                res.overflow = sat_seen;
                res.last = 1;
                pending.push_back(res);
            end else begin
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        res.value = grid[at(r, n + c)];
                        res.singular = 0;
                        res.overflow = sat_seen;
                        res.last = (r == n - 1) && (c == n - 1);
                        pending.push_back(res);
                    end
                end
            end
            loaded = 0;
            sat_seen = 0;
        endfunction

        function void check(logic signed [31:0] v, logic s, logic o, logic l);
            inv_result_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual val=%h sing=%b ovf=%b last=%b",
                         $realtime, v, s, o, l);
                return;
            end
            e = pending.pop_front();
            if (v !== e.value || s !== e.singular || o !== e.overflow || l !== e.last) begin
                errors++;
                $display("%0t: mismatch expected val=%h sing=%b ovf=%b last=%b",
                         $realtime, e.value, e.singular, e.overflow, e.last);
                $display("%0t:          actual   val=%h sing=%b ovf=%b last=%b",
                         $realtime, v, s, o, l);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_elem_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_inv_value;
    logic               o_singular;
    logic               o_overflow;
    logic               o_last_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_data;

    inverse_scoreboard  sb;
    bit                 gaps_on;
    int                 hold_req;
    int                 elems_sent;

    matrix_inverse_gauss_jordan dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_elem_value (i_elem_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inv_value  (o_inv_value),
        .o_singular   (o_singular),
        .o_overflow   (o_overflow),
        .o_last_out   (o_last_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("matrix_inverse_gauss_jordan test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check(o_inv_value, o_singular, o_overflow, o_last_out);
    end

    initial begin
        int hold_left;
        int burst;
        hold_left = 0;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1;
                hold_left--;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1;
                burst = $urandom_range(1, 13);
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall <= 0;
            end
        end
    end

    task automatic send_elem(logic signed [31:0] v);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_elem_value <= v;
        do @(posedge i_clk); while (o_stall);
        sb.note_elem(v);
        elems_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_size(logic [3:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_size(v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic logic signed [31:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return ($urandom_range(0, 1) != 0) ? 32'sh00010000 : 32'shffff0000;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    task automatic send_matrix(int n);
        for (int i = 0; i < n * n; i++) send_elem(pick_elem());
    endtask

    initial begin
        int n;
        int reps;
        sb = new();
        sb.clear();
        gaps_on = 1;
        hold_req = 0;
        elems_sent = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_elem_value = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        write_size(1);
        send_elem(32'sh00010000);
        send_elem(0);
        send_elem(32'sh80000000);
        send_elem(32'sh7fffffff);
        send_elem(1);
        write_size(0);
        send_elem(32'shffff0000);
        write_size(2);
        send_elem(0); send_elem(32'sh00010000); send_elem(32'sh00010000); send_elem(0);
        send_elem(0); send_elem(0); send_elem(0); send_elem(0);
        send_elem(32'sh00020000); send_elem(32'sh00030000);
        write_size(2);
        send_elem(32'sh7fffffff); send_elem(32'sh80000000);
        send_elem(32'sh00000001); send_elem(32'sh00010000);
        write_size(15);
        send_matrix(8);
        write_size(9);
        send_matrix(1);

        write_size(2);
        hold_req = 3000;
        for (int m = 0; m < 6; m++) send_matrix(2);

        while (elems_sent < 430) begin
            if (elems_sent > 360) gaps_on = 0;
            case ($urandom_range(0, 19))
                0: n = 8;
                1: n = $urandom_range(5, 7);
                2: n = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15);
                default: n = $urandom_range(1, 4);
            endcase
            write_size(4'(n));
            if (n < 1) n = 1;
            if (n > mig_pkg::MAX_N) n = mig_pkg::MAX_N;
            reps = (n > 4) ? 1 : $urandom_range(1, 3);
            for (int m = 0; m < reps; m++) send_matrix(n);
        end
        gaps_on = 0;
        drain();

        if (sb.errors == 0) begin
            $display("matrix_inverse_gauss_jordan test passed");
        end else begin
            $display("matrix_inverse_gauss_jordan test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/mig_pkg.sv
design/mig_div.sv
design/mig_datapath.sv
design/mig_ctrl.sv
design/matrix_inverse_gauss_jordan.sv
tb/tb_matrix_inverse_gauss_jordan.sv
